// File: sv/sqfo_pkg.sv
// Package for the stereo quadratic fade-out core.
// Holds field widths, register indexes and the sequencer state type.
// No dependencies.
package sqfo_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int TOTAL_W   = 32;
    localparam int FADE_W    = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int QUO_W     = 17;   // quotient and gain, up to 65536
    localparam int MUL_A_W   = 18;   // signed multiplicand
    localparam int ACC_W     = 35;   // signed product accumulator
    localparam int STEP_W    = 5;    // counts 17 serial steps
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TOTAL_FRAMES = 2'd0,
        REG_FADE_FRAMES  = 2'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_SQUARE,
        ST_SCALE,
        ST_DONE
    } seq_state_t;

endpackage

// File: sv/sqfo_if.sv
// Valid/ready channel interfaces of the fade-out core.
// Depends on sqfo_pkg.
interface sqfo_frame_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sqfo_pkg::SAMPLE_W-1:0] left_sample;
    logic signed [sqfo_pkg::SAMPLE_W-1:0] right_sample;

    modport source (output valid, left_sample, right_sample, input ready);
    modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface sqfo_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sqfo_pkg::SAMPLE_W-1:0] left_out;
    logic signed [sqfo_pkg::SAMPLE_W-1:0] right_out;
    logic                                 last;

    modport source (output valid, left_out, right_out, last, input ready);
    modport sink   (input valid, left_out, right_out, last, output ready);
endinterface

interface sqfo_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [sqfo_pkg::CFG_ADDR_W-1:0]     addr;
    logic [sqfo_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// File: sv/sqfo_div.sv
// Restoring divider, one quotient bit per cycle: q = floor(num * 2^16 / den).
// Requires num <= den, so q <= 65536. Depends on sqfo_pkg.
module sqfo_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [sqfo_pkg::FADE_W-1:0]      num,
    input  logic [sqfo_pkg::FADE_W-1:0]      den,
    output logic                             done,
    output logic [sqfo_pkg::QUO_W-1:0]       quo
);

    logic [sqfo_pkg::FADE_W:0]     rem_reg, rem_next;
    logic [sqfo_pkg::FADE_W-1:0]   den_reg;
    logic [sqfo_pkg::QUO_W-1:0]    quo_reg;
    logic [sqfo_pkg::STEP_W-1:0]   cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [sqfo_pkg::FADE_W:0]     trial;
    logic                          ge;

    always_comb
    begin
        trial = (cnt_reg == '0) ? rem_reg : {rem_reg[sqfo_pkg::FADE_W-1:0], 1'b0};
        ge    = trial >= {1'b0, den_reg};
        rem_next = ge ? trial - {1'b0, den_reg} : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == sqfo_pkg::LAST_STEP);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == sqfo_pkg::LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[sqfo_pkg::QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: sv/sqfo_mul.sv
// Bit-serial shift-add multiplier lane: signed a times unsigned b, MSB of b first.
// 17 steps; done pulses when the product is final. Depends on sqfo_pkg.
module sqfo_mul
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [sqfo_pkg::MUL_A_W-1:0] a,
    input  logic [sqfo_pkg::QUO_W-1:0]          b,
    output logic                                done,
    output logic signed [sqfo_pkg::ACC_W-1:0]   prod
);

    logic signed [sqfo_pkg::ACC_W-1:0]   acc_reg;
    logic signed [sqfo_pkg::MUL_A_W-1:0] a_reg;
    logic [sqfo_pkg::QUO_W-1:0]          b_reg;
    logic [sqfo_pkg::STEP_W-1:0]         cnt_reg;
    logic                                busy_reg;
    logic                                done_reg;
    logic signed [sqfo_pkg::ACC_W-1:0]   addend;

    assign addend = b_reg[sqfo_pkg::QUO_W-1]
                  ? {{(sqfo_pkg::ACC_W-sqfo_pkg::MUL_A_W){a_reg[sqfo_pkg::MUL_A_W-1]}}, a_reg}
                  : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == sqfo_pkg::LAST_STEP);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == sqfo_pkg::LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            acc_reg <= (acc_reg <<< 1) + addend;
            b_reg   <= {b_reg[sqfo_pkg::QUO_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: sv/stereo_quadratic_fade_out_core.sv
// Top level of the stereo quadratic fade-out core: frame counter, sequencer,
// serial divider and two serial multiplier lanes.
// Depends on sqfo_pkg, sqfo_if, sqfo_div, sqfo_mul.
//
//  channel  modport  word
//  frame    sink     left_sample, right_sample
//  result   source   left_out, right_out, last
//  cfg      sink     addr, data (0 total_frames, 1 fade_frames)
//
// Pass-through frames pass IDLE, DECIDE and DONE; frames inside the fade run the
// 17-step divider followed by two 17-step serial multiplies
// (gain = q*q / 2^16, then both channels in parallel) between DECIDE and DONE.
// A finished track drops the frame in DECIDE with no word out.
// rst_n clears the frame count and both registers; cfg is always ready.
// A new frame is taken while a result word still waits on a stalled sink.
module stereo_quadratic_fade_out_core
(
    input  logic          clk,
    input  logic          rst_n,
    sqfo_frame_if.sink    frame,
    sqfo_result_if.source result,
    sqfo_cfg_if.sink      cfg
);

    sqfo_pkg::seq_state_t state_reg, state_next;

    logic [sqfo_pkg::TOTAL_W-1:0]          total_reg;
    logic [sqfo_pkg::FADE_W-1:0]           fade_reg;
    logic [sqfo_pkg::TOTAL_W-1:0]          played_reg;
    logic [sqfo_pkg::TOTAL_W-1:0]          remaining_reg;
    logic                                  finished_reg;
    logic                                  fading_reg;
    logic                                  last_reg;
    logic signed [sqfo_pkg::SAMPLE_W-1:0]  left_reg;
    logic signed [sqfo_pkg::SAMPLE_W-1:0]  right_reg;

    logic                                  out_valid_reg;
    logic signed [sqfo_pkg::SAMPLE_W-1:0]  out_left_reg;
    logic signed [sqfo_pkg::SAMPLE_W-1:0]  out_right_reg;
    logic                                  out_last_reg;

    logic                                  fade_ok;
    logic                                  out_free;
    logic                                  take;
    logic                                  frame_ready;
    logic                                  div_start;
    logic                                  sq_start;
    logic                                  scale_start;
    logic                                  out_load;

    logic                                  div_done;
    logic [sqfo_pkg::QUO_W-1:0]            quo;
    logic                                  mul0_done;
    logic                                  mul1_done;
    logic signed [sqfo_pkg::ACC_W-1:0]     prod0;
    logic signed [sqfo_pkg::ACC_W-1:0]     prod1;
    logic [sqfo_pkg::QUO_W-1:0]            gain;
    logic signed [sqfo_pkg::MUL_A_W-1:0]   mul0_a;
    logic [sqfo_pkg::QUO_W-1:0]            mul0_b;
    logic signed [sqfo_pkg::MUL_A_W-1:0]   mul1_a;

    assign fade_ok  = (fade_reg != '0) &&
                      (remaining_reg <= {{(sqfo_pkg::TOTAL_W-sqfo_pkg::FADE_W){1'b0}}, fade_reg});
    assign out_free = !out_valid_reg || result.ready;
    assign take     = frame.valid && frame_ready;
    assign gain     = prod0[2*sqfo_pkg::SAMPLE_W:sqfo_pkg::SAMPLE_W];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sqfo_pkg::ST_IDLE:
            begin
                if (frame.valid)
                begin
                    state_next = sqfo_pkg::ST_DECIDE;
                end
            end
            sqfo_pkg::ST_DECIDE:
            begin
                priority if (finished_reg)
                    state_next = sqfo_pkg::ST_IDLE;
                else if (fade_ok)
                    state_next = sqfo_pkg::ST_DIV;
                else
                    state_next = sqfo_pkg::ST_DONE;
            end
            sqfo_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = sqfo_pkg::ST_SQUARE;
                end
            end
            sqfo_pkg::ST_SQUARE:
            begin
                if (mul0_done)
                begin
                    state_next = sqfo_pkg::ST_SCALE;
                end
            end
            sqfo_pkg::ST_SCALE:
            begin
                if (mul0_done && mul1_done)
                begin
                    state_next = sqfo_pkg::ST_DONE;
                end
            end
            sqfo_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = sqfo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sqfo_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        frame_ready = 1'b0;
        div_start   = 1'b0;
        sq_start    = 1'b0;
        scale_start = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            sqfo_pkg::ST_IDLE:   frame_ready = 1'b1;
            sqfo_pkg::ST_DECIDE: div_start   = !finished_reg && fade_ok;
            sqfo_pkg::ST_DIV:    sq_start    = div_done;
            sqfo_pkg::ST_SQUARE: scale_start = mul0_done;
            sqfo_pkg::ST_SCALE:  ;
            sqfo_pkg::ST_DONE:   out_load    = out_free;
            default:             ;
        endcase
    end

    always_comb
    begin
        if (scale_start)
        begin
            mul0_a = {left_reg[sqfo_pkg::SAMPLE_W-1],
                      left_reg[sqfo_pkg::SAMPLE_W-1], left_reg};
            mul0_b = gain;
        end
        else
        begin
            mul0_a = {1'b0, quo};
            mul0_b = quo;
        end
        mul1_a = {right_reg[sqfo_pkg::SAMPLE_W-1], right_reg[sqfo_pkg::SAMPLE_W-1], right_reg};
    end

    sqfo_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (remaining_reg[sqfo_pkg::FADE_W-1:0]),
        .den   (fade_reg),
        .done  (div_done),
        .quo   (quo)
    );

    sqfo_mul u_mul_left
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start || scale_start),
        .a     (mul0_a),
        .b     (mul0_b),
        .done  (mul0_done),
        .prod  (prod0)
    );

    sqfo_mul u_mul_right
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scale_start),
        .a     (mul1_a),
        .b     (gain),
        .done  (mul1_done),
        .prod  (prod1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sqfo_pkg::ST_IDLE;
            total_reg     <= '0;
            fade_reg      <= '0;
            played_reg    <= '0;
            finished_reg  <= 1'b0;
            fading_reg    <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                unique case (cfg.addr)
                    sqfo_pkg::REG_TOTAL_FRAMES: total_reg <= cfg.data;
                    sqfo_pkg::REG_FADE_FRAMES:  fade_reg  <= cfg.data[sqfo_pkg::FADE_W-1:0];
                    default:                    ;
                endcase
            end

            if (take)
            begin
                finished_reg <= played_reg >= total_reg;
            end

            if ((state_reg == sqfo_pkg::ST_DECIDE) && !finished_reg)
            begin
                played_reg <= played_reg + 1'b1;
                fading_reg <= fade_ok;
                last_reg   <= remaining_reg == {{(sqfo_pkg::TOTAL_W-1){1'b0}}, 1'b1};
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            left_reg      <= frame.left_sample;
            right_reg     <= frame.right_sample;
            remaining_reg <= total_reg - played_reg;
        end
        if (out_load)
        begin
            out_last_reg <= last_reg;
            if (fading_reg)
            begin
                out_left_reg  <= prod0[2*sqfo_pkg::SAMPLE_W-1:sqfo_pkg::SAMPLE_W];
                out_right_reg <= prod1[2*sqfo_pkg::SAMPLE_W-1:sqfo_pkg::SAMPLE_W];
            end
            else
            begin
                out_left_reg  <= left_reg;
                out_right_reg <= right_reg;
            end
        end
    end

    assign frame.ready      = frame_ready;
    assign cfg.ready        = 1'b1;
    assign result.valid     = out_valid_reg;
    assign result.left_out  = out_left_reg;
    assign result.right_out = out_right_reg;
    assign result.last      = out_last_reg;

endmodule
